FILE: hdl/lpfr_pkg.sv
// Shared types and constants of the laser pulse frame receiver.
// Used by lpfr_ctrl, lpfr_dpath and laser_pulse_frame_receiver; depends on nothing.
package lpfr_pkg;

  // Widths fixed by the interface
  localparam int TICK_BITS     = 12;
  localparam int CFG_BITS      = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int MEDIAN_BITS   = 12;
  localparam int PHASE_BITS    = 4;
  localparam int OUT_DATA_BITS = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PREPARE_WAIT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_MIN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_HOLD     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_WAIT      = 3'd4;

  // Configuration reset values
  localparam logic [CFG_BITS-1:0] RST_PREPARE_WAIT  = 12'd2000;
  localparam logic [CFG_BITS-1:0] RST_PULSE_MIN     = 12'd10;
  localparam logic [CFG_BITS-1:0] RST_PULSE_TIMEOUT = 12'd40;
  localparam logic [CFG_BITS-1:0] RST_DATA_HOLD     = 12'd20;
  localparam logic [CFG_BITS-1:0] RST_END_WAIT      = 12'd2000;

  // Reported phase codes
  localparam logic [PHASE_BITS-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_PREPARE = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_START   = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_PRE1    = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_PRE2    = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_PRE3    = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_DATA    = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_CHECK   = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_END     = 4'd8;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_PREPARE = 9'b000000010,
    ST_START   = 9'b000000100,
    ST_PRE1    = 9'b000001000,
    ST_PRE2    = 9'b000010000,
    ST_PRE3    = 9'b000100000,
    ST_DATA    = 9'b001000000,
    ST_CHECK   = 9'b010000000,
    ST_END     = 9'b100000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;
    logic clear_timer;
    logic insert;
    logic take_median;
    logic upd_level;
    logic upd_data;
  } cmd_t;

  // Status from datapath to controller (timer compares use the ticked timer)
  typedef struct packed {
    logic gt_prepare;
    logic gt_min;
    logic gt_timeout;
    logic gt_hold;
    logic gt_end;
    logic store_full;
    logic median_nz;
    logic level_hi;
    logic data_bit;
  } status_t;

  // Values the datapath will hold after the current request
  typedef struct packed {
    logic                   level_bit;
    logic                   data_bit;
    logic [MEDIAN_BITS-1:0] median;
  } result_t;

endpackage

FILE: hdl/lpfr_ctrl.sv
// Phase controller of the laser pulse frame receiver.
// Depends on lpfr_pkg for state, command and status types.
module lpfr_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_fire,
  input  lpfr_pkg::status_t               status,
  output lpfr_pkg::cmd_t                  cmd,
  output logic [lpfr_pkg::PHASE_BITS-1:0] phase_code,
  output logic                            frame_done
);

  lpfr_pkg::state_t state_r, state_nxt;
  logic             clr;
  logic             done;
  logic             hi;

  // Walk the transitions in their fixed order; a cleared timer reads as zero
  always_comb begin
    hi        = status.level_hi;
    state_nxt = state_r;
    clr       = 1'b0;
    done      = 1'b0;
    if (state_nxt == lpfr_pkg::ST_IDLE) begin
      state_nxt = lpfr_pkg::ST_PREPARE;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PREPARE && status.gt_prepare && !clr && status.store_full) begin
      state_nxt = lpfr_pkg::ST_START;
    end
    if (state_nxt == lpfr_pkg::ST_START && status.median_nz) begin
      state_nxt = lpfr_pkg::ST_PRE1;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PRE1 && hi && status.gt_min && !clr) begin
      state_nxt = lpfr_pkg::ST_PRE2;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PRE2 && !hi) begin
      state_nxt = lpfr_pkg::ST_PRE1;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PRE2 && hi && status.gt_min && !clr) begin
      state_nxt = lpfr_pkg::ST_PRE3;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PRE3 && !hi && status.gt_min && !clr) begin
      state_nxt = lpfr_pkg::ST_DATA;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_PRE3 && hi && status.gt_timeout && !clr) begin
      state_nxt = lpfr_pkg::ST_PRE1;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_CHECK && (hi != status.data_bit) && status.gt_hold && !clr) begin
      state_nxt = lpfr_pkg::ST_END;
      clr       = 1'b1;
      done      = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_CHECK && (hi == status.data_bit)) begin
      state_nxt = lpfr_pkg::ST_PRE1;
      clr       = 1'b1;
    end
    if (state_nxt == lpfr_pkg::ST_END && status.gt_end && !clr) begin
      state_nxt = lpfr_pkg::ST_PREPARE;
    end
    if (state_nxt == lpfr_pkg::ST_DATA && status.gt_hold && !clr) begin
      state_nxt = lpfr_pkg::ST_CHECK;
      clr       = 1'b1;
    end
  end

  // Drive the action of the phase reached
  always_comb begin
    cmd.step        = item_fire;
    cmd.clear_timer = clr;
    cmd.insert      = (state_nxt == lpfr_pkg::ST_PREPARE);
    cmd.take_median = (state_nxt == lpfr_pkg::ST_START);
    cmd.upd_level   = (state_nxt == lpfr_pkg::ST_PRE1) || (state_nxt == lpfr_pkg::ST_PRE2) ||
                      (state_nxt == lpfr_pkg::ST_PRE3) || (state_nxt == lpfr_pkg::ST_DATA) ||
                      (state_nxt == lpfr_pkg::ST_CHECK);
    cmd.upd_data    = (state_nxt == lpfr_pkg::ST_DATA);
    frame_done      = done;
  end

  // Encode the reported phase
  always_comb begin
    unique case (state_nxt)
      lpfr_pkg::ST_IDLE:    phase_code = lpfr_pkg::PH_IDLE;
      lpfr_pkg::ST_PREPARE: phase_code = lpfr_pkg::PH_PREPARE;
      lpfr_pkg::ST_START:   phase_code = lpfr_pkg::PH_START;
      lpfr_pkg::ST_PRE1:    phase_code = lpfr_pkg::PH_PRE1;
      lpfr_pkg::ST_PRE2:    phase_code = lpfr_pkg::PH_PRE2;
      lpfr_pkg::ST_PRE3:    phase_code = lpfr_pkg::PH_PRE3;
      lpfr_pkg::ST_DATA:    phase_code = lpfr_pkg::PH_DATA;
      lpfr_pkg::ST_CHECK:   phase_code = lpfr_pkg::PH_CHECK;
      lpfr_pkg::ST_END:     phase_code = lpfr_pkg::PH_END;
      default:              phase_code = lpfr_pkg::PH_IDLE;
    endcase
  end

  // Advance the phase once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpfr_pkg::ST_IDLE;
    end else if (item_fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/lpfr_dpath.sv
// Datapath of the laser pulse frame receiver: config registers, tick timer,
// sorted calibration store, median and light level. Depends on lpfr_pkg.
module lpfr_dpath #(
  parameter int CALIB_SAMPLES = 17,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lpfr_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [lpfr_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]            light_sample,
  input  logic                              ms_tick,
  input  lpfr_pkg::cmd_t                    cmd,
  output lpfr_pkg::status_t                 status,
  output lpfr_pkg::result_t                 result
);

  localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam int MID   = CALIB_SAMPLES / 2;
  localparam int CMP_W = ((SAMPLE_BITS > lpfr_pkg::MEDIAN_BITS) ? SAMPLE_BITS
                                                                : lpfr_pkg::MEDIAN_BITS) + 3;

  logic [lpfr_pkg::CFG_BITS-1:0]  prepare_wait_r, pulse_min_r, pulse_timeout_r;
  logic [lpfr_pkg::CFG_BITS-1:0]  data_hold_r, end_wait_r;
  logic [lpfr_pkg::TICK_BITS-1:0] elapsed_r, elapsed_inc;
  logic [SAMPLE_BITS-1:0]         sorted_r [CALIB_SAMPLES];
  logic [CNT_W-1:0]               count_r;
  logic [lpfr_pkg::MEDIAN_BITS-1:0] median_r;
  logic                           level_r, data_r;
  logic [CALIB_SAMPLES-1:0]       lt, eq;
  logic                           dup, full, do_insert;
  logic [CMP_W-1:0]               sample5, median7;
  logic                           level_calc;

  // Hold configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prepare_wait_r  <= lpfr_pkg::RST_PREPARE_WAIT;
      pulse_min_r     <= lpfr_pkg::RST_PULSE_MIN;
      pulse_timeout_r <= lpfr_pkg::RST_PULSE_TIMEOUT;
      data_hold_r     <= lpfr_pkg::RST_DATA_HOLD;
      end_wait_r      <= lpfr_pkg::RST_END_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lpfr_pkg::CFG_PREPARE_WAIT:  prepare_wait_r  <= cfg_wdata;
        lpfr_pkg::CFG_PULSE_MIN:     pulse_min_r     <= cfg_wdata;
        lpfr_pkg::CFG_PULSE_TIMEOUT: pulse_timeout_r <= cfg_wdata;
        lpfr_pkg::CFG_DATA_HOLD:     data_hold_r     <= cfg_wdata;
        lpfr_pkg::CFG_END_WAIT:      end_wait_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturating tick count, then compare against the limits
  assign elapsed_inc = (ms_tick && (elapsed_r != '1)) ? elapsed_r + 1'b1 : elapsed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cmd.step) begin
      elapsed_r <= cmd.clear_timer ? '0 : elapsed_inc;
    end
  end

  // Compare the sample against every filled cell of the sorted chain
  always_comb begin
    for (int i = 0; i < CALIB_SAMPLES; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (sorted_r[i] < light_sample);
      eq[i] = (CNT_W'(i) < count_r) && (sorted_r[i] == light_sample);
    end
  end

  assign dup       = |eq;
  assign full      = (count_r == CNT_W'(CALIB_SAMPLES));
  assign do_insert = cmd.step && cmd.insert && !full && !dup;

  // Insert by shifting every cell above the slot up by one
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < CALIB_SAMPLES; i++) begin
        if (!lt[i]) begin
          if (i == 0) begin
            sorted_r[i] <= light_sample;
          end else if (lt[i-1]) begin
            sorted_r[i] <= light_sample;
          end else begin
            sorted_r[i] <= sorted_r[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_insert) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Light threshold: sample*5 >= median*7, or full scale
  assign sample5    = CMP_W'(light_sample) * CMP_W'(5);
  assign median7    = CMP_W'(median_r) * CMP_W'(7);
  assign level_calc = (sample5 >= median7) || (light_sample == '1);

  always_comb begin
    result.level_bit = cmd.upd_level ? level_calc : level_r;
    result.data_bit  = cmd.upd_data ? level_calc : data_r;
    result.median    = cmd.take_median ? lpfr_pkg::MEDIAN_BITS'(sorted_r[MID]) : median_r;
  end

  // Advance median and level state per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      median_r <= '0;
      level_r  <= 1'b0;
      data_r   <= 1'b0;
    end else if (cmd.step) begin
      median_r <= result.median;
      level_r  <= result.level_bit;
      data_r   <= result.data_bit;
    end
  end

  // Report status to the controller
  always_comb begin
    status.gt_prepare = elapsed_inc > prepare_wait_r;
    status.gt_min     = elapsed_inc > pulse_min_r;
    status.gt_timeout = elapsed_inc > pulse_timeout_r;
    status.gt_hold    = elapsed_inc > data_hold_r;
    status.gt_end     = elapsed_inc > end_wait_r;
    status.store_full = full;
    status.median_nz  = (median_r != '0);
    status.level_hi   = level_r;
    status.data_bit   = data_r;
  end

endmodule

FILE: hdl/laser_pulse_frame_receiver.sv
// Laser pulse frame receiver, top level.
// The result of a request is registered as the request is accepted and is offered in the cycle after.
// Throughput: one request per cycle while the held result is not stalled; the sorted compare chain is combinational.
// The output register takes a new request while the held result is being taken.
// Reset (rst_n low, synchronous): idle phase, timer, count, median and levels cleared,
// config back to defaults; the calibration store holds no reset and needs no clear pass.
module laser_pulse_frame_receiver #(
  parameter int CALIB_SAMPLES = 17,
  parameter int SAMPLE_BITS   = 12,
  localparam int IN_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_W-1:0]                      in_tdata,  // light_sample, ms_tick, zero pad
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lpfr_pkg::OUT_DATA_BITS-1:0]   out_tdata, // phase[3:0], light_high,
                                                          // received_bit, frame_done,
                                                          // ambient_median[11:0], pad
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpfr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lpfr_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int RES_W = lpfr_pkg::PHASE_BITS + 3 + lpfr_pkg::MEDIAN_BITS;

  logic                            in_fire;
  lpfr_pkg::cmd_t                  cmd;
  lpfr_pkg::status_t               status;
  lpfr_pkg::result_t               result;
  logic [lpfr_pkg::PHASE_BITS-1:0] phase_code;
  logic                            frame_done;
  logic                            out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]                out_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  lpfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (in_fire),
    .status     (status),
    .cmd        (cmd),
    .phase_code (phase_code),
    .frame_done (frame_done)
  );

  lpfr_dpath #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .light_sample (in_tdata[SAMPLE_BITS-1:0]),
    .ms_tick      (in_tdata[SAMPLE_BITS]),
    .cmd          (cmd),
    .status       (status),
    .result       (result)
  );

  // Hold the result until the sink takes it
  assign out_valid_nxt = in_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {result.median, frame_done, result.data_bit, result.level_bit, phase_code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lpfr_pkg::OUT_DATA_BITS'(out_data_r);

endmodule

FILE: tb/lpfr_checker.sv
// Scoreboard for the laser pulse frame receiver: snoops the request, result and
// config channels, predicts every result and compares it field by field.
// Depends on lpfr_pkg for phase codes, register indexes and reset values.
`timescale 1ns / 1ps
module lpfr_checker #(
  parameter int CALIB_SAMPLES = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // light_sample[11:0], ms_tick, zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // phase[3:0], light_high, received_bit,
                                  // frame_done, ambient_median[11:0], pad
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          frames
);

  localparam logic [11:0] TICK_SAT   = 12'hFFF;
  localparam logic [11:0] FULL_SCALE = 12'hFFF;

  // One result, lowest field in the lowest bits
  typedef struct packed {
    logic [11:0] median;
    logic        frame_done;
    logic        received_bit;
    logic        light_high;
    logic [3:0]  phase;
  } rx_result_t;

  // Predicted receiver state
  logic [3:0]  phase_q;
  logic [11:0] elapsed_q;
  logic [11:0] calib_store [CALIB_SAMPLES];
  int          stored;
  logic [11:0] median_q;
  logic        level_q;
  logic        bit_q;

  // Predicted config copy
  logic [11:0] prep_wait, pulse_min, pulse_tmo, data_hold, end_wait;

  rx_result_t expected_results [$];
  int         mismatches;

  task automatic reset_receiver();
    phase_q   = lpfr_pkg::PH_IDLE;
    elapsed_q = '0;
    stored    = 0;
    median_q  = '0;
    level_q   = 1'b0;
    bit_q     = 1'b0;
    prep_wait = lpfr_pkg::RST_PREPARE_WAIT;
    pulse_min = lpfr_pkg::RST_PULSE_MIN;
    pulse_tmo = lpfr_pkg::RST_PULSE_TIMEOUT;
    data_hold = lpfr_pkg::RST_DATA_HOLD;
    end_wait  = lpfr_pkg::RST_END_WAIT;
    for (int k = 0; k < CALIB_SAMPLES; k++) calib_store[k] = '0;
  endtask

  task automatic write_config(input logic [2:0] idx, input logic [11:0] val);
    case (idx)
      lpfr_pkg::CFG_PREPARE_WAIT:  prep_wait = val;
      lpfr_pkg::CFG_PULSE_MIN:     pulse_min = val;
      lpfr_pkg::CFG_PULSE_TIMEOUT: pulse_tmo = val;
      lpfr_pkg::CFG_DATA_HOLD:     data_hold = val;
      lpfr_pkg::CFG_END_WAIT:      end_wait  = val;
      default: ;
    endcase
  endtask

  // Insert a new sample in ascending order; drop duplicates and drop all once full
  task automatic insert_sample(input logic [11:0] s);
    int pos;
    pos = 0;
    if (stored >= CALIB_SAMPLES) return;
    while (pos < stored && calib_store[pos] < s) pos++;
    if (pos < stored && calib_store[pos] == s) return;
    for (int k = stored; k > pos; k--) calib_store[k] = calib_store[k - 1];
    calib_store[pos] = s;
    stored++;
  endtask

  function automatic logic level_of(input logic [11:0] s);
    int unsigned lhs, rhs;
    lhs = 32'(s) * 5;
    rhs = 32'(median_q) * 7;
    return (lhs >= rhs) || (s == FULL_SCALE);
  endfunction

  task automatic move_to(input logic [3:0] nxt, input bit restart);
    phase_q = nxt;
    if (restart) elapsed_q = '0;
  endtask

  // Advance the receiver by one request and produce its result
  task automatic step_receiver(input logic [11:0] s, input logic tick, output rx_result_t r);
    logic hi, done;
    hi   = level_q;
    done = 1'b0;
    if (tick && elapsed_q < TICK_SAT) elapsed_q = elapsed_q + 1'b1;

    // Transitions, each one sees the phase left by the ones above it
    if (phase_q == lpfr_pkg::PH_IDLE) move_to(lpfr_pkg::PH_PREPARE, 1);
    if (phase_q == lpfr_pkg::PH_PREPARE && elapsed_q > prep_wait && stored >= CALIB_SAMPLES)
      move_to(lpfr_pkg::PH_START, 0);
    if (phase_q == lpfr_pkg::PH_START && median_q != 0) move_to(lpfr_pkg::PH_PRE1, 1);
    if (phase_q == lpfr_pkg::PH_PRE1 && hi && elapsed_q > pulse_min)
      move_to(lpfr_pkg::PH_PRE2, 1);
    if (phase_q == lpfr_pkg::PH_PRE2 && !hi) move_to(lpfr_pkg::PH_PRE1, 1);
    if (phase_q == lpfr_pkg::PH_PRE2 && hi && elapsed_q > pulse_min)
      move_to(lpfr_pkg::PH_PRE3, 1);
    if (phase_q == lpfr_pkg::PH_PRE3 && !hi && elapsed_q > pulse_min)
      move_to(lpfr_pkg::PH_DATA, 1);
    if (phase_q == lpfr_pkg::PH_PRE3 && hi && elapsed_q > pulse_tmo)
      move_to(lpfr_pkg::PH_PRE1, 1);
    if (phase_q == lpfr_pkg::PH_CHECK && level_q != bit_q && elapsed_q > data_hold) begin
      move_to(lpfr_pkg::PH_END, 1);
      done = 1'b1;
    end
    if (phase_q == lpfr_pkg::PH_CHECK && level_q == bit_q) move_to(lpfr_pkg::PH_PRE1, 1);
    if (phase_q == lpfr_pkg::PH_END && elapsed_q > end_wait) move_to(lpfr_pkg::PH_PREPARE, 0);
    if (phase_q == lpfr_pkg::PH_DATA && elapsed_q > data_hold) move_to(lpfr_pkg::PH_CHECK, 1);

    // Action of the phase now reached
    case (phase_q)
      lpfr_pkg::PH_PREPARE: insert_sample(s);
      lpfr_pkg::PH_START:   median_q = calib_store[CALIB_SAMPLES / 2];
      lpfr_pkg::PH_PRE1, lpfr_pkg::PH_PRE2, lpfr_pkg::PH_PRE3, lpfr_pkg::PH_CHECK:
        level_q = level_of(s);
      lpfr_pkg::PH_DATA: begin
        level_q = level_of(s);
        bit_q   = level_q;
      end
      default: ;
    endcase

    r.phase        = phase_q;
    r.light_high   = level_q;
    r.received_bit = bit_q;
    r.frame_done   = done;
    r.median       = median_q;
  endtask

  task automatic report(input string what, input rx_result_t want, input rx_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected phase=%0d high=%0b bit=%0b done=%0b median=%0d,",
               $time, what, want.phase, want.light_high, want.received_bit,
               want.frame_done, want.median);
      $display("    got phase=%0d high=%0b bit=%0b done=%0b median=%0d",
               got.phase, got.light_high, got.received_bit, got.frame_done, got.median);
    end
  endtask

  initial begin
    errors     = 0;
    pending    = 0;
    checked    = 0;
    frames     = 0;
    mismatches = 0;
    reset_receiver();
  end

  // Retire results first, then take config writes and new requests
  always @(posedge clk) begin : watch
    rx_result_t got, want, nxt;
    if (!rst_n) begin
      reset_receiver();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[18:0];
        if (expected_results.size() == 0) begin
          errors++;
          report("result with no request pending", '0, got);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.frame_done) frames++;
          if (got !== want) begin
            errors++;
            report("result mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) write_config(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        step_receiver(in_tdata[11:0], in_tdata[12], nxt);
        expected_results.push_back(nxt);
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/tb_laser_pulse_frame_receiver.sv
// Top of the laser pulse frame receiver testbench: clock, reset, config writes,
// request and result stream driving with random gaps; verdict from lpfr_checker.
// Depends on lpfr_pkg, lpfr_checker and the laser_pulse_frame_receiver RTL.
`timescale 1ns / 1ps
module tb_laser_pulse_frame_receiver;

  // Calibration list below gives a median of 95, so high means sample >= 133
  localparam int LOW_MAX         = 132;
  localparam int HIGH_MIN        = 133;
  localparam int FULL_SCALE      = 4095;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int IDLE_PCT        = 21;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  int errors, pending, checked, frames;
  int idle_pct;
  int items_sent;
  int cycles;
  bit hold_off_armed;
  int cur_min, cur_tmo, cur_hold, cur_end;

  laser_pulse_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lpfr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .frames     (frames)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Abort on a hang
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int  stall_left;
    bit  stall_used;
    stall_left = 0;
    stall_used = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_armed && !stall_used) begin
        stall_used = 1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= !(idle_pct != 0 && $urandom_range(0, 99) < idle_pct);
      end
    end
  end

  // Offer one request, with random gaps ahead of it; entered and left at a falling edge
  task automatic send_item(input logic [11:0] s, input logic tick);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, tick, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input int prep, input int pmin, input int tmo, input int hold,
                            input int endw);
    write_reg(lpfr_pkg::CFG_PREPARE_WAIT, prep[11:0]);
    write_reg(lpfr_pkg::CFG_PULSE_MIN, pmin[11:0]);
    write_reg(lpfr_pkg::CFG_PULSE_TIMEOUT, tmo[11:0]);
    write_reg(lpfr_pkg::CFG_DATA_HOLD, hold[11:0]);
    write_reg(lpfr_pkg::CFG_END_WAIT, endw[11:0]);
    cfg_valid <= 1'b0;
    cur_min  = pmin;
    cur_tmo  = tmo;
    cur_hold = hold;
    cur_end  = endw;
  endtask

  // Random sample on one side of the threshold, edges favored
  function automatic logic [11:0] pick_sample(input bit hi);
    int r;
    r = $urandom_range(0, 7);
    if (hi) begin
      if (r == 0) return 12'(HIGH_MIN);
      if (r == 1) return 12'(FULL_SCALE);
      return 12'($urandom_range(HIGH_MIN, FULL_SCALE));
    end
    if (r == 0) return 12'(LOW_MAX);
    if (r == 1) return 12'd0;
    return 12'($urandom_range(0, LOW_MAX));
  endfunction

  // Hold one light level for a given number of ms ticks, with tickless requests mixed in
  task automatic hold_level(input bit hi, input int ticks);
    int done_ticks;
    logic tick;
    done_ticks = 0;
    while (done_ticks < ticks) begin
      tick = ($urandom_range(0, 3) != 0);
      send_item(pick_sample(hi), tick);
      if (tick) done_ticks++;
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(12'($urandom_range(0, FULL_SCALE)), 1'($urandom_range(0, 1)));
  endtask

  // Preamble, data bit and check, mostly well formed, sometimes broken
  task automatic send_frame();
    int  kind;
    bit  data_hi;
    int  pmin_len;
    kind    = $urandom_range(0, 9);
    data_hi = 1'($urandom_range(0, 1));
    pmin_len = (kind == 9) ? $urandom_range(0, cur_min) : cur_min + 2 + $urandom_range(0, 2);
    hold_level(1, cur_min + 2 + $urandom_range(0, 2));
    hold_level(0, pmin_len);
    hold_level(1, cur_min + 2 + $urandom_range(0, 2));
    if (kind == 8) begin
      // stay high past the timeout of the third pulse, held at most 62 ticks
      hold_level(1, (cur_tmo > 60 ? 60 : cur_tmo) + 2);
      return;
    end
    hold_level(0, cur_min + 2 + $urandom_range(0, 2));
    hold_level(data_hi, cur_hold + 2 + $urandom_range(0, 2));
    // repeat of the same level sends the receiver back to the preamble
    hold_level((kind == 7) ? data_hi : !data_hi, cur_hold + 2 + $urandom_range(0, 2));
    if (kind != 7) send_noise(cur_end + 3 + $urandom_range(0, 3));
  endtask

  task automatic run_random(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
      else send_frame();
    end
  endtask

  initial begin : stimulus
    logic [11:0] calib_list [19];
    calib_list = '{12'd4095, 12'd0, 12'd100, 12'd100, 12'd60, 12'd4095, 12'd80, 12'd120,
                   12'd90, 12'd110, 12'd70, 12'd130, 12'd95, 12'd85, 12'd105, 12'd115,
                   12'd75, 12'd65, 12'd2048};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    idle_pct       = IDLE_PCT;
    items_sent     = 0;
    hold_off_armed = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short waits so frames come quickly
    set_config(2, 1, 5, 1, 3);

    // Calibration: extremes, duplicates, then samples after the store is full
    foreach (calib_list[i]) send_item(calib_list[i], 1'(i % 2));
    send_item(12'd1, 1'b1);
    send_item(12'd0, 1'b1);
    send_item(12'd4095, 1'b0);
    send_item(12'd4094, 1'b1);
    send_item(12'd133, 1'b1);
    send_item(12'd132, 1'b1);

    run_random(120);
    // Block the result side while requests keep coming
    hold_off_armed = 1;
    run_random(60);
    drain_results();
    run_random(120);
    drain_results();

    // All waits at zero, no idling on either side; spare indexes must be ignored
    idle_pct = 0;
    for (int idx = int'(lpfr_pkg::CFG_END_WAIT) + 1; idx < 8; idx++)
      write_reg(3'(idx), 12'($urandom_range(0, FULL_SCALE)));
    set_config(0, 0, 0, 0, 0);
    run_random(220);
    drain_results();

    // Longest prepare wait, no pre3 timeout
    idle_pct = IDLE_PCT;
    set_config(4000, 3, 4000, 4, 0);
    run_random(150);
    drain_results();

    repeat (4) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results, %0d frames ended;",
             items_sent, checked, frames);
    $display("config sets: short waits, all zero, 4000-tick prepare wait, long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
